[rtl/core/p2x_pkg.sv]
// shared types, register codes and the quad rule of the 2x upscaler
package p2x_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 11;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam int Q_DEPTH = 4;
  localparam int Q_CNT_W = 3;
  localparam int Q_PUSH  = 3;

  typedef struct packed {
    logic [7:0] top_left;
    logic [7:0] top_right;
    logic [7:0] bottom_left;
    logic [7:0] bottom_right;
    logic [9:0] src_col;
    logic [9:0] src_row;
    logic       frame_end;
  } quad_t;

  function automatic quad_t make_quad(input logic [7:0] b, input logic [7:0] d,
                                      input logic [7:0] e, input logic [7:0] f,
                                      input logic [7:0] h, input logic [9:0] x,
                                      input logic [9:0] y, input logic fe);
    quad_t q;
    q.top_left     = (d == b && b != f && d != h) ? d : e;
    q.top_right    = (b == f && b != d && f != h) ? f : e;
    q.bottom_left  = (d == h && d != b && h != f) ? d : e;
    q.bottom_right = (h == f && d != h && b != f) ? f : e;
    q.src_col      = x;
    q.src_row      = y;
    q.frame_end    = fe;
    return q;
  endfunction

endpackage

[rtl/core/p2x_ram.sv]
// generic single-clock ram, one write and one registered read port
module p2x_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (re) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[rtl/core/p2x_out_queue.sv]
// output quad queue, takes up to three quads a cycle, hands out one per beat
module p2x_out_queue (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [1:0]                 push_n,
  input  p2x_pkg::quad_t             push_q [p2x_pkg::Q_PUSH],
  input  logic                       out_stall,
  output logic                       out_valid,
  output p2x_pkg::quad_t             head,
  output logic [p2x_pkg::Q_CNT_W-1:0] space
);

  localparam int DEPTH = p2x_pkg::Q_DEPTH;
  localparam int CW    = p2x_pkg::Q_CNT_W;

  p2x_pkg::quad_t q      [DEPTH];
  p2x_pkg::quad_t q_next [DEPTH];
  logic [CW-1:0]  count;
  logic [CW-1:0]  count_next;
  logic [CW-1:0]  base;
  logic           pop;

  always_comb begin
    pop  = (count != '0) && !out_stall;
    base = count - CW'(pop);
    for (int i = 0; i < DEPTH; i++) begin
      q_next[i] = q[i];
    end
    if (pop) begin
      for (int i = 0; i < DEPTH - 1; i++) begin
        q_next[i] = q[i + 1];
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      for (int j = 0; j < p2x_pkg::Q_PUSH; j++) begin
        if (CW'(j) < CW'(push_n) && base + CW'(j) == CW'(i)) begin
          q_next[i] = push_q[j];
        end
      end
    end
    count_next = base + CW'(push_n);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      q[i] <= q_next[i];
    end
  end

  assign out_valid = (count != '0);
  assign head      = q[0];
  assign space     = CW'(DEPTH) - count;

endmodule

[rtl/core/pixel_art_2x_upscaler.sv]
// scale2x upscaler top level: counters, line store pipeline and output queue
//
// Source pixels enter in raster order, one per beat, and each gives up to
// three output quads of 2x2 pixels. Inside a frame the block takes one pixel
// per clock while the output queue has room for its quads. On the last row of
// a frame taller than one row, every pixel after the first yields two quads,
// so there the output port (one quad per beat) sets the pace. The final pixel
// of the frame adds one more quad. A single-row frame yields one quad per
// pixel after the first and keeps the full rate. A pixel goes through a
// two-stage pipeline (count and read, then compute and write back) and a
// four-entry output queue. The line store is one ram of MAX_WIDTH words
// holding the two rows above for each column, read one column ahead and
// rewritten once per pixel. It has no reset and needs no clearing pass, since
// a word read before its column is written in the frame never reaches a
// quad. A write to the width or height register restarts the frame.
// The configuration port is always ready, but writes belong only where the
// block is idle, with no pixel or quad in flight.
module pixel_art_2x_upscaler #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [p2x_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [p2x_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      pixel,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [7:0]                      top_left,
  output logic [7:0]                      top_right,
  output logic [7:0]                      bottom_left,
  output logic [7:0]                      bottom_right,
  output logic [9:0]                      src_col,
  output logic [9:0]                      src_row,
  output logic                            frame_end
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam logic [12:0] MAXW13 = 13'(MAX_WIDTH);
  localparam logic [12:0] MAXH13 = 13'(MAX_HEIGHT);

  typedef struct packed {
    logic [7:0] up;
    logic [7:0] up2;
  } col_word_t;

  typedef struct packed {
    logic col_ge1;
    logic col_ge2;
    logic last_col;
    logic row_ge1;
    logic row_ge2;
    logic last_row;
    logic rd_self;
  } pos_flags_t;

  // configuration and counters
  logic [p2x_pkg::CFG_DATA_W-1:0] image_width;
  logic [p2x_pkg::CFG_DATA_W-1:0] image_height;
  logic [CW-1:0] width_last;
  logic [RW-1:0] height_last;
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;

  always_comb begin
    if (image_width == '0) begin
      width_last = '0;
    end else if (13'(image_width) > MAXW13) begin
      width_last = CW'(MAX_WIDTH - 1);
    end else begin
      width_last = CW'(image_width - 11'd1);
    end
    if (image_height == '0) begin
      height_last = '0;
    end else if (13'(image_height) > MAXH13) begin
      height_last = RW'(MAX_HEIGHT - 1);
    end else begin
      height_last = RW'(image_height - 11'd1);
    end
  end

  logic       accept;
  logic       s1_adv;
  logic       s1_valid;
  pos_flags_t s0_flags;
  logic [CW-1:0] rd_addr;

  assign cfg_ready = 1'b1;
  assign accept    = in_valid && !in_stall;
  assign in_stall  = s1_valid && !s1_adv;

  always_comb begin
    s0_flags.col_ge1  = (col_count != '0);
    s0_flags.col_ge2  = (col_count > CW'(1));
    s0_flags.last_col = (col_count == width_last);
    s0_flags.row_ge1  = (row_count != '0);
    s0_flags.row_ge2  = (row_count > RW'(1));
    s0_flags.last_row = (row_count == height_last);
    s0_flags.rd_self  = s0_flags.last_col && (col_count == '0);
    rd_addr = s0_flags.last_col ? '0 : col_count + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 11'd320;
      image_height <= 11'd200;
      col_count    <= '0;
      row_count    <= '0;
      s1_valid     <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (accept) begin
        if (!s0_flags.last_col) begin
          col_count <= col_count + CW'(1);
        end else begin
          col_count <= '0;
          row_count <= s0_flags.last_row ? '0 : row_count + RW'(1);
        end
      end
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          p2x_pkg::REG_IMAGE_WIDTH: begin
            image_width <= cfg_data;
            col_count   <= '0;
            row_count   <= '0;
          end
          p2x_pkg::REG_IMAGE_HEIGHT: begin
            image_height <= cfg_data;
            col_count    <= '0;
            row_count    <= '0;
          end
          default: begin
          end
        endcase
      end
    end
  end

  // stage 1 payload and line store window
  logic [7:0]    s1_pix;
  logic [CW-1:0] s1_col;
  logic [RW-1:0] s1_row;
  pos_flags_t    s1_flags;
  col_word_t     word_c;
  col_word_t     ram_rd;
  col_word_t     fwd_rd;
  col_word_t     wr_word;
  col_word_t     byp_data;
  logic          byp_hit;
  logic [7:0]    up_left;
  logic [7:0]    prev_p;
  logic [7:0]    prev2_p;

  assign wr_word = '{up: s1_pix, up2: word_c.up};
  assign fwd_rd  = byp_hit ? byp_data : ram_rd;

  p2x_ram #(
    .WIDTH($bits(col_word_t)),
    .DEPTH(MAX_WIDTH)
  ) u_line_store (
    .clk    (clk),
    .we     (s1_adv),
    .wr_addr(s1_col),
    .wr_data(wr_word),
    .re     (accept),
    .rd_addr(rd_addr),
    .rd_data(ram_rd)
  );

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix   <= pixel;
      s1_col   <= col_count;
      s1_row   <= row_count;
      s1_flags <= s0_flags;
      byp_hit  <= s1_adv && (rd_addr == s1_col);
      byp_data <= wr_word;
    end
    if (s1_adv) begin
      up_left <= word_c.up;
      word_c  <= s1_flags.rd_self ? wr_word : fwd_rd;
      prev2_p <= prev_p;
      prev_p  <= s1_pix;
    end
  end

  // quad computation
  logic [9:0]  col10;
  logic [9:0]  colm1_10;
  logic [9:0]  row10;
  logic [9:0]  rowm1_10;
  logic [7:0]  e1, b1, d1, f1;
  logic [7:0]  e2, b2, d2;
  logic [7:0]  b3, d3;
  p2x_pkg::quad_t q1, q2, q3;
  p2x_pkg::quad_t push_q [p2x_pkg::Q_PUSH];
  logic [1:0]  push_n;
  logic [1:0]  n1;
  logic [p2x_pkg::Q_CNT_W-1:0] q_space;
  p2x_pkg::quad_t head;

  always_comb begin
    col10    = 10'(s1_col);
    colm1_10 = 10'(s1_col - CW'(1));
    row10    = 10'(s1_row);
    rowm1_10 = 10'(s1_row - RW'(1));

    e1 = word_c.up;
    b1 = s1_flags.row_ge2 ? word_c.up2 : e1;
    d1 = s1_flags.col_ge1 ? up_left : e1;
    f1 = !s1_flags.last_col ? fwd_rd.up : e1;
    q1 = p2x_pkg::make_quad(b1, d1, e1, f1, s1_pix, col10, rowm1_10, 1'b0);

    e2 = prev_p;
    b2 = s1_flags.row_ge1 ? up_left : e2;
    d2 = s1_flags.col_ge2 ? prev2_p : e2;
    q2 = p2x_pkg::make_quad(b2, d2, e2, s1_pix, e2, colm1_10, row10, 1'b0);

    b3 = s1_flags.row_ge1 ? word_c.up : s1_pix;
    d3 = s1_flags.col_ge1 ? prev_p : s1_pix;
    q3 = p2x_pkg::make_quad(b3, d3, s1_pix, s1_pix, s1_pix, col10, row10, 1'b1);

    for (int j = 0; j < p2x_pkg::Q_PUSH; j++) begin
      push_q[j] = q1;
    end
    n1 = '0;
    if (s1_flags.row_ge1) begin
      push_q[n1] = q1;
      n1 = n1 + 2'd1;
    end
    if (s1_flags.last_row && s1_flags.col_ge1) begin
      push_q[n1] = q2;
      n1 = n1 + 2'd1;
    end
    if (s1_flags.last_row && s1_flags.last_col) begin
      push_q[n1] = q3;
      n1 = n1 + 2'd1;
    end
  end

  assign s1_adv = s1_valid && (p2x_pkg::Q_CNT_W'(n1) <= q_space);
  assign push_n = s1_adv ? n1 : 2'd0;

  p2x_out_queue u_out_queue (
    .clk      (clk),
    .rst      (rst),
    .push_n   (push_n),
    .push_q   (push_q),
    .out_stall(out_stall),
    .out_valid(out_valid),
    .head     (head),
    .space    (q_space)
  );

  assign top_left     = head.top_left;
  assign top_right    = head.top_right;
  assign bottom_left  = head.bottom_left;
  assign bottom_right = head.bottom_right;
  assign src_col      = head.src_col;
  assign src_row      = head.src_row;
  assign frame_end    = head.frame_end;

endmodule

[bench/pixel_art_2x_upscaler_tb.sv]
// self-checking bench for the scale2x upscaler: raster stimulus, quad prediction, random idling
module pixel_art_2x_upscaler_tb;

  localparam int LINE_W       = 1024;
  localparam int ROWS_MAX     = 1024;
  localparam int DRAIN_CYCLES = 8;
  localparam int RAND_ITEMS   = 285;
  localparam int CYCLE_LIMIT  = 600000;

  class quad_scoreboard;
    logic [7:0]      rows [0:3*LINE_W-1];
    logic [10:0]     width_reg;
    logic [10:0]     height_reg;
    logic [10:0]     col_cnt;
    logic [10:0]     row_cnt;
    logic [1:0]      slot;
    p2x_pkg::quad_t  expected [$];
    int              errors;
    int              checked;
    int              frames;

    function new();
      foreach (rows[i]) rows[i] = 8'd0;
      width_reg  = 11'd320;
      height_reg = 11'd200;
      col_cnt    = '0;
      row_cnt    = '0;
      slot       = '0;
      errors     = 0;
      checked    = 0;
      frames     = 0;
    endfunction

    function int eff_dim(logic [10:0] v, int max_v);
      if (v == 0) return 1;
      if (int'(v) > max_v) return max_v;
      return int'(v);
    endfunction

    function logic [7:0] fetch(int s, int c);
      return rows[(s % 3) * LINE_W + c];
    endfunction

    function void push_quad(logic [7:0] b, logic [7:0] d, logic [7:0] e, logic [7:0] f,
                            logic [7:0] h, int x, int y, logic fe);
      p2x_pkg::quad_t q;
      q.top_left     = (d == b && b != f && d != h) ? d : e;
      q.top_right    = (b == f && b != d && f != h) ? f : e;
      q.bottom_left  = (d == h && d != b && h != f) ? d : e;
      q.bottom_right = (h == f && d != h && b != f) ? f : e;
      q.src_col      = x[9:0];
      q.src_row      = y[9:0];
      q.frame_end    = fe;
      expected.push_back(q);
    endfunction

    function void write_reg(logic [1:0] idx, logic [10:0] data);
      if (idx == p2x_pkg::REG_IMAGE_WIDTH) width_reg = data;
      else if (idx == p2x_pkg::REG_IMAGE_HEIGHT) height_reg = data;
      else return;
      col_cnt = '0;
      row_cnt = '0;
      slot    = '0;
    endfunction

    function void note_pixel(logic [7:0] p);
      int w, h, c, r, cur, up, up2, x;
      logic [7:0] b, d, e, f;
      w   = eff_dim(width_reg, LINE_W);
      h   = eff_dim(height_reg, ROWS_MAX);
      c   = int'(col_cnt);
      r   = int'(row_cnt);
      if (c >= w) c = w - 1;
      if (r >= h) r = h - 1;
      cur = int'(slot);
      up  = (cur + 2) % 3;
      up2 = (cur + 1) % 3;
      rows[cur * LINE_W + c] = p;
      // row above, completed by the pixel below
      if (r >= 1) begin
        e = fetch(up, c);
        b = (r >= 2) ? fetch(up2, c) : e;
        d = (c > 0) ? fetch(up, c - 1) : e;
        f = (c + 1 < w) ? fetch(up, c + 1) : e;
        push_quad(b, d, e, f, p, c, r - 1, 1'b0);
      end
      // last row: previous column, then own quad at the frame end
      if (r == h - 1) begin
        if (c >= 1) begin
          x = c - 1;
          e = fetch(cur, x);
          b = (r >= 1) ? fetch(up, x) : e;
          d = (x > 0) ? fetch(cur, x - 1) : e;
          push_quad(b, d, e, p, e, x, r, 1'b0);
        end
        if (c == w - 1) begin
          b = (r >= 1) ? fetch(up, c) : p;
          d = (c > 0) ? fetch(cur, c - 1) : p;
          push_quad(b, d, p, p, p, c, r, 1'b1);
        end
      end
      if (c + 1 < w) begin
        col_cnt = 11'(c + 1);
        row_cnt = 11'(r);
      end else if (r + 1 < h) begin
        col_cnt = '0;
        row_cnt = 11'(r + 1);
        slot    = 2'((cur + 1) % 3);
      end else begin
        col_cnt = '0;
        row_cnt = '0;
        slot    = '0;
        frames++;
      end
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      end
    endfunction

    function void check_quad(p2x_pkg::quad_t got);
      p2x_pkg::quad_t want;
      if (expected.size() == 0) begin
        errors++;
        $display("%0t: unexpected quad, expected none actual col %0d row %0d", $time,
                 got.src_col, got.src_row);
        return;
      end
      want = expected.pop_front();
      checked++;
      check_field("top_left", want.top_left, got.top_left);
      check_field("top_right", want.top_right, got.top_right);
      check_field("bottom_left", want.bottom_left, got.bottom_left);
      check_field("bottom_right", want.bottom_right, got.bottom_right);
      check_field("src_col", want.src_col, got.src_col);
      check_field("src_row", want.src_row, got.src_row);
      check_field("frame_end", want.frame_end, got.frame_end);
    endfunction

    function int pending();
      return expected.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [p2x_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [p2x_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [7:0] pixel = 8'd0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] top_left;
  logic [7:0] top_right;
  logic [7:0] bottom_left;
  logic [7:0] bottom_right;
  logic [9:0] src_col;
  logic [9:0] src_row;
  logic frame_end;

  quad_scoreboard sb;
  int burst_left = 0;
  int pixels_sent = 0;
  int cfg_writes = 0;
  int pauses = 0;
  int cycles = 0;
  int stall_mode = 0;
  int stall_left = 0;
  logic [7:0] palette [3];

  pixel_art_2x_upscaler u_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel        (pixel),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .top_left     (top_left),
    .top_right    (top_right),
    .bottom_left  (bottom_left),
    .bottom_right (bottom_right),
    .src_col      (src_col),
    .src_row      (src_row),
    .frame_end    (frame_end)
  );

  always #4 clk = ~clk;

  // receiver stall pattern, switching at random among four modes
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(20, 120);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 3) == 0);
      2: out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= stall_left[3];
    endcase
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      sb.check_quad('{top_left, top_right, bottom_left, bottom_right,
                      src_col, src_row, frame_end});
    end
  end

  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("%0t: timeout with %0d quads outstanding", $time, sb.pending());
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int eff_dim(int v, int max_v);
    if (v == 0) return 1;
    if (v > max_v) return max_v;
    return v;
  endfunction

  function automatic logic [7:0] pick_pixel();
    if ($urandom_range(0, 9) < 7) return palette[$urandom_range(0, 2)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(input logic [7:0] p);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if ($urandom_range(0, 15) == 0) gap = $urandom_range(10, 40);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
    in_valid <= 1'b1;
    pixel    <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_pixel(p);
    burst_left--;
    pixels_sent++;
  endtask

  task automatic hold_for_results();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    pauses++;
  endtask

  task automatic write_cfg(input logic [1:0] idx, input logic [10:0] data);
    hold_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.write_reg(idx, data);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    logic [7:0] grid [9];
    int kind, w_val, h_val, n_frames, count, pause_at, odd_at, rand_items;
    bit partial, force_pause;
    grid = '{8'd7, 8'd7, 8'd200, 8'd7, 8'd0, 8'd200, 8'd255, 8'd255, 8'd200};
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: full 3x3 frame, zero size, oversize width and height
    write_cfg(p2x_pkg::REG_IMAGE_WIDTH, 11'd3);
    write_cfg(p2x_pkg::REG_IMAGE_HEIGHT, 11'd3);
    foreach (grid[i]) send_pixel(grid[i]);
    write_cfg(p2x_pkg::REG_IMAGE_WIDTH, 11'd0);
    write_cfg(p2x_pkg::REG_IMAGE_HEIGHT, 11'd0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    write_cfg(p2x_pkg::REG_IMAGE_WIDTH, 11'h7FF);
    write_cfg(p2x_pkg::REG_IMAGE_HEIGHT, 11'd1);
    send_pixel(8'd255);
    send_pixel(8'd255);
    send_pixel(8'd0);
    send_pixel(8'd0);
    send_pixel(8'd255);
    send_pixel(8'd0);
    write_cfg(p2x_pkg::REG_IMAGE_WIDTH, 11'd2);
    write_cfg(p2x_pkg::REG_IMAGE_HEIGHT, 11'h7FF);
    send_pixel(8'd9);
    send_pixel(8'd9);
    send_pixel(8'd9);
    send_pixel(8'd40);
    // writes to unused indexes leave the frame running
    write_cfg(2'd2, 11'h7FF);
    send_pixel(8'd40);
    send_pixel(8'd9);
    write_cfg(2'd3, 11'd0);
    send_pixel(8'd9);
    send_pixel(8'd40);

    rand_items  = 0;
    force_pause = 1'b1;
    while (rand_items < RAND_ITEMS) begin
      partial = 1'b0;
      kind = $urandom_range(0, 9);
      case (kind)
        0: begin
          w_val = 0;
          h_val = $urandom_range(1, 5);
        end
        1: begin
          w_val = $urandom_range(1024, 2047);
          h_val = $urandom_range(0, 2);
          partial = 1'b1;
        end
        2: begin
          w_val = $urandom_range(1, 6);
          h_val = 0;
        end
        3: begin
          w_val = $urandom_range(1, 3);
          h_val = $urandom_range(1024, 2047);
          partial = 1'b1;
        end
        4: begin
          w_val = $urandom_range(9, 40);
          h_val = $urandom_range(1, 4);
        end
        default: begin
          w_val = $urandom_range(1, 8);
          h_val = $urandom_range(1, 6);
        end
      endcase
      write_cfg(p2x_pkg::REG_IMAGE_WIDTH, 11'(w_val));
      write_cfg(p2x_pkg::REG_IMAGE_HEIGHT, 11'(h_val));
      foreach (palette[i]) palette[i] = 8'($urandom_range(0, 255));
      n_frames = partial ? 1 : $urandom_range(1, 3);
      for (int fr = 0; fr < n_frames; fr++) begin
        count = eff_dim(w_val, LINE_W) * eff_dim(h_val, ROWS_MAX);
        if (partial) count = $urandom_range(8, 40);
        else if ($urandom_range(0, 6) == 0) begin
          count = $urandom_range(1, count);
          partial = 1'b1;
        end
        pause_at = (force_pause || $urandom_range(0, 4) == 0) ? $urandom_range(0, count - 1) : -1;
        odd_at = ($urandom_range(0, 9) == 0) ? $urandom_range(0, count - 1) : -1;
        force_pause = 1'b0;
        for (int i = 0; i < count && rand_items < RAND_ITEMS; i++) begin
          if (i == pause_at) hold_for_results();
          if (i == odd_at) write_cfg(2'($urandom_range(2, 3)), 11'($urandom_range(0, 2047)));
          send_pixel(pick_pixel());
          rand_items++;
        end
        if (partial) break;
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES * 4) @(posedge clk);
    $display("covered %0d pixels over %0d register writes and %0d full frames,", pixels_sent,
             cfg_writes, sb.frames);
    $display("%0d quads compared, %0d sender pauses, %0d field errors", sb.checked, pauses,
             sb.errors);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
